FILE: rtl/mwmm_pkg.sv
// ---------------------------------------------------------------------------
// mwmm_pkg
// Shared types and constants for the multi-window running min/max block.
// ---------------------------------------------------------------------------
package mwmm_pkg;

  // Default sizing
  localparam int DEF_HISTORY_DEPTH = 256;
  localparam int DEF_PRICE_WIDTH   = 32;

  // Window count and register geometry
  localparam int NUM_WIN   = 4;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP   = 3'd4;

  // Register reset values
  localparam logic [CFG_W-1:0] RST_WINDOW_A = 9'd15;
  localparam logic [CFG_W-1:0] RST_WINDOW_B = 9'd30;
  localparam logic [CFG_W-1:0] RST_WINDOW_C = 9'd60;
  localparam logic [CFG_W-1:0] RST_WINDOW_D = 9'd180;
  localparam logic [CFG_W-1:0] RST_WARMUP   = 9'd180;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_EMIT,
    ST_STORE
  } seq_state_t;

  // Control from sequencer to the compare unit
  typedef struct packed {
    logic               acc_en;  // history word valid this cycle
    logic               first;   // word is the newest entry (k == 1)
    logic [NUM_WIN-1:0] snap;    // capture running result for window j
  } scan_ctl_t;

endpackage

FILE: rtl/mwmm_hist.sv
// ---------------------------------------------------------------------------
// mwmm_hist
// History ring storage: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module mwmm_hist #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/mwmm_cmp.sv
// ---------------------------------------------------------------------------
// mwmm_cmp
// Shared compare unit: running min of lows and max of highs over the
// backward scan, with a snapshot per window length.
// ---------------------------------------------------------------------------
module mwmm_cmp #(
  parameter int PRICE_WIDTH = 32
) (
  input  logic                                         clk,
  input  mwmm_pkg::scan_ctl_t                          ctl,
  input  logic [PRICE_WIDTH-1:0]                       hist_lo,
  input  logic [PRICE_WIDTH-1:0]                       hist_hi,
  output logic [2*mwmm_pkg::NUM_WIN*PRICE_WIDTH-1:0]   result
);

  import mwmm_pkg::*;

  logic [PRICE_WIDTH-1:0] acc_lo;
  logic [PRICE_WIDTH-1:0] acc_hi;
  logic [PRICE_WIDTH-1:0] acc_lo_next;
  logic [PRICE_WIDTH-1:0] acc_hi_next;
  logic [PRICE_WIDTH-1:0] snap_lo [NUM_WIN];
  logic [PRICE_WIDTH-1:0] snap_hi [NUM_WIN];

  // one signed compare for each bound
  always_comb begin
    acc_lo_next = acc_lo;
    acc_hi_next = acc_hi;
    if (ctl.first || ($signed(hist_lo) < $signed(acc_lo))) begin
      acc_lo_next = hist_lo;
    end
    if (ctl.first || ($signed(hist_hi) > $signed(acc_hi))) begin
      acc_hi_next = hist_hi;
    end
  end

  // running accumulators
  always_ff @(posedge clk) begin
    if (ctl.acc_en) begin
      acc_lo <= acc_lo_next;
      acc_hi <= acc_hi_next;
    end
  end

  // per-window snapshots, taken with the current word included
  always_ff @(posedge clk) begin
    for (int j = 0; j < NUM_WIN; j++) begin
      if (ctl.acc_en && ctl.snap[j]) begin
        snap_lo[j] <= acc_lo_next;
        snap_hi[j] <= acc_hi_next;
      end
    end
  end

  // pack: support_a, resistance_a, support_b, ... from the low bits up
  always_comb begin
    for (int j = 0; j < NUM_WIN; j++) begin
      result[(2*j)*PRICE_WIDTH +: PRICE_WIDTH]   = snap_lo[j];
      result[(2*j+1)*PRICE_WIDTH +: PRICE_WIDTH] = snap_hi[j];
    end
  end

endmodule

FILE: rtl/mwmm_seq.sv
// ---------------------------------------------------------------------------
// mwmm_seq
// Sequencer: config registers, warmup/window clamping, ring pointer,
// seen count, and the backward scan over the history.
// ---------------------------------------------------------------------------
module mwmm_seq #(
  parameter int HISTORY_DEPTH = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  // config write
  input  logic                               cfg_wr,
  input  logic [mwmm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mwmm_pkg::CFG_W-1:0]         cfg_data,
  // input handshake
  input  logic                               in_valid,
  output logic                               in_ready,
  // output register status
  input  logic                               out_free,
  output logic                               out_load,
  // history access
  output logic                               hist_we,
  output logic [$clog2(HISTORY_DEPTH)-1:0]   hist_waddr,
  output logic                               hist_re,
  output logic [$clog2(HISTORY_DEPTH)-1:0]   hist_raddr,
  // compare unit control
  output mwmm_pkg::scan_ctl_t                ctl
);

  import mwmm_pkg::*;

  localparam int AW  = $clog2(HISTORY_DEPTH);
  localparam int NW  = $clog2(HISTORY_DEPTH + 1);
  localparam int CW  = (NW > CFG_W) ? NW : CFG_W;

  localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);
  localparam logic [AW-1:0] LAST_C  = AW'(HISTORY_DEPTH - 1);

  seq_state_t state, state_next;

  logic [CFG_W-1:0] cfg_win [NUM_WIN];
  logic [CFG_W-1:0] cfg_warm;

  logic [CW-1:0] warm_eff;
  logic [CW-1:0] len_eff [NUM_WIN];
  logic [CW-1:0] warm;
  logic [CW-1:0] len [NUM_WIN];
  logic [CW-1:0] items_seen;
  logic [CW-1:0] kiss;
  logic [CW-1:0] kd;
  logic          rd_v;
  logic          hit;
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic          accept;

  assign accept = in_valid && in_ready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_win[0] <= RST_WINDOW_A;
      cfg_win[1] <= RST_WINDOW_B;
      cfg_win[2] <= RST_WINDOW_C;
      cfg_win[3] <= RST_WINDOW_D;
      cfg_warm   <= RST_WARMUP;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_WINDOW_A: cfg_win[0] <= cfg_data;
        CFG_WINDOW_B: cfg_win[1] <= cfg_data;
        CFG_WINDOW_C: cfg_win[2] <= cfg_data;
        CFG_WINDOW_D: cfg_win[3] <= cfg_data;
        CFG_WARMUP:   cfg_warm   <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp warmup to [1, depth], windows to [1, warmup]
  always_comb begin
    warm_eff = CW'(cfg_warm);
    if (warm_eff == '0) begin
      warm_eff = ONE_C;
    end else if (warm_eff > DEPTH_C) begin
      warm_eff = DEPTH_C;
    end
    for (int j = 0; j < NUM_WIN; j++) begin
      len_eff[j] = CW'(cfg_win[j]);
      if (len_eff[j] == '0) begin
        len_eff[j] = ONE_C;
      end else if (len_eff[j] > warm_eff) begin
        len_eff[j] = warm_eff;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (items_seen >= warm_eff) ? ST_SCAN : ST_STORE;
        end
      end
      ST_SCAN: begin
        if (kiss == warm) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_STORE;
        end
      end
      ST_STORE: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready   = (state == ST_IDLE);
    hist_re    = (state == ST_SCAN);
    hist_raddr = rp;
    hist_we    = (state == ST_STORE);
    hist_waddr = wp;
    out_load   = (state == ST_EMIT) && out_free && hit;
    ctl.acc_en = rd_v;
    ctl.first  = (kd == ONE_C);
    for (int j = 0; j < NUM_WIN; j++) begin
      ctl.snap[j] = (kd == len[j]);
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ring pointer and seen count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp         <= '0;
      items_seen <= '0;
    end else if (state == ST_STORE) begin
      wp         <= (wp == LAST_C) ? '0 : wp + AW'(1);
      items_seen <= (items_seen < warm) ? items_seen + ONE_C : warm;
    end
  end

  // scan counters
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
    end else begin
      rd_v <= (state == ST_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      warm <= warm_eff;
      hit  <= (items_seen >= warm_eff);
      for (int j = 0; j < NUM_WIN; j++) begin
        len[j] <= len_eff[j];
      end
      kiss <= ONE_C;
      rp   <= (wp == '0) ? LAST_C : wp - AW'(1);
    end else if (state == ST_SCAN) begin
      kd   <= kiss;
      kiss <= kiss + ONE_C;
      rp   <= (rp == '0) ? LAST_C : rp - AW'(1);
    end
  end

endmodule

FILE: rtl/multi_window_running_min_max_top.sv
// ---------------------------------------------------------------------------
// multi_window_running_min_max_top
// Running minimum of lows and maximum of highs over four trailing windows.
// ---------------------------------------------------------------------------
// Each word carries a low and a high sample (signed fixed point). Once the
// history holds at least warmup earlier samples, each word yields one result
// word with the min low and max high over the last window_a..window_d samples,
// the current sample excluded; before that no result is sent. Windows are
// clamped to [1, warmup] and warmup to [1, HISTORY_DEPTH]. For an item with
// a result, the backward scan reads one history entry per cycle from a
// single read port and feeds one shared compare unit; the item then waits
// while the result register is still held. An item without a result only
// stores its sample. The input is not ready while an item is in work; the
// output is registered and can hold a result while the next word is taken.
module multi_window_running_min_max_top #(
  parameter int HISTORY_DEPTH = mwmm_pkg::DEF_HISTORY_DEPTH,
  parameter int PRICE_WIDTH   = mwmm_pkg::DEF_PRICE_WIDTH
) (
  input  logic                                          clk,
  input  logic                                          rst,
  // configuration write channel
  input  logic                                          cfg_valid,
  output logic                                          cfg_ready,
  input  logic [mwmm_pkg::CFG_IDX_W-1:0]                cfg_index,
  input  logic [mwmm_pkg::CFG_W-1:0]                    cfg_data,
  // input stream
  input  logic                                          s_axis_tvalid,
  output logic                                          s_axis_tready,
  // low_price, high_price, zero pad to whole bytes
  input  logic [((2*PRICE_WIDTH+7)/8)*8-1:0]            s_axis_tdata,
  // output stream
  output logic                                          m_axis_tvalid,
  input  logic                                          m_axis_tready,
  // support_a, resistance_a, support_b, resistance_b,
  // support_c, resistance_c, support_d, resistance_d
  output logic [2*mwmm_pkg::NUM_WIN*PRICE_WIDTH-1:0]    m_axis_tdata
);

  import mwmm_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int OW = 2 * NUM_WIN * PRICE_WIDTH;

  scan_ctl_t               ctl;
  logic                    out_free;
  logic                    out_load;
  logic                    hist_we;
  logic                    hist_re;
  logic [AW-1:0]           hist_waddr;
  logic [AW-1:0]           hist_raddr;
  logic [2*PRICE_WIDTH-1:0] hist_rdata;
  logic [2*PRICE_WIDTH-1:0] sample;
  logic [OW-1:0]           result;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  // hold the accepted sample until it is stored
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      sample <= s_axis_tdata[2*PRICE_WIDTH-1:0];
    end
  end

  mwmm_seq #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .out_free   (out_free),
    .out_load   (out_load),
    .hist_we    (hist_we),
    .hist_waddr (hist_waddr),
    .hist_re    (hist_re),
    .hist_raddr (hist_raddr),
    .ctl        (ctl)
  );

  mwmm_hist #(
    .DEPTH (HISTORY_DEPTH),
    .WIDTH (2 * PRICE_WIDTH)
  ) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (sample),
    .re    (hist_re),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  mwmm_cmp #(
    .PRICE_WIDTH (PRICE_WIDTH)
  ) u_cmp (
    .clk     (clk),
    .ctl     (ctl),
    .hist_lo (hist_rdata[PRICE_WIDTH-1:0]),
    .hist_hi (hist_rdata[2*PRICE_WIDTH-1:PRICE_WIDTH]),
    .result  (result)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= result;
    end
  end

endmodule
